### design/assert_macros.svh
// Assertion macros used by the encoder controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at each rising edge, skipped while reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("lpse: assertion failed");
// Check a property at each rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("lpse: assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### design/lpse_pkg.sv
// Types and constants of the LED pixel SPI encoder
`default_nettype none
package lpse_pkg;

	localparam int unsigned FUNC_W      = 2;
	localparam int unsigned IDX_IN_W    = 6;
	localparam int unsigned COLOR_W     = 8;
	localparam int unsigned PIXEL_W     = 3 * COLOR_W;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned LED_COUNT_W = 7;
	localparam int unsigned TAIL_W      = 8;

	// operation codes of an input word
	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR = 2'd0,
		FN_WRITE = 2'd1,
		FN_START = 2'd2,
		FN_TICK  = 2'd3
	} func_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CODE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_CODE    = 2'd3;

	// register reset values
	localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST   = 7'd64;
	localparam logic [TAIL_W-1:0]      RESET_BYTES_RST = 8'd240;
	localparam logic [COLOR_W-1:0]     HIGH_CODE_RST   = 8'hF0;
	localparam logic [COLOR_W-1:0]     LOW_CODE_RST    = 8'hC0;

	// color send order within one LED
	localparam logic [1:0] COL_GREEN = 2'd0;
	localparam logic [1:0] COL_RED   = 2'd1;
	localparam logic [1:0] COL_BLUE  = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic sweep;
	} lpse_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
		logic clear_go;
		logic sweep_last;
	} lpse_stat_t;

endpackage
`default_nettype wire

### design/lpse_item_if.sv
// Input word channel of the LED pixel SPI encoder
`default_nettype none
interface lpse_item_if;
	import lpse_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [IDX_IN_W-1:0] pixel_index;
	logic [COLOR_W-1:0]  red;
	logic [COLOR_W-1:0]  green;
	logic [COLOR_W-1:0]  blue;

	modport source (output valid, func, pixel_index, red, green, blue, input ready);
	modport sink (input valid, func, pixel_index, red, green, blue, output ready);
endinterface
`default_nettype wire

### design/lpse_result_if.sv
// Result word channel of the LED pixel SPI encoder
`default_nettype none
interface lpse_result_if;
	import lpse_pkg::*;

	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] spi_byte;
	logic               byte_valid;
	logic               last;
	logic               status;

	modport source (output valid, spi_byte, byte_valid, last, status, input ready);
	modport sink (input valid, spi_byte, byte_valid, last, status, output ready);
endinterface
`default_nettype wire

### design/lpse_cfg_if.sv
// Configuration write channel of the LED pixel SPI encoder
`default_nettype none
interface lpse_cfg_if;
	import lpse_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/led_pixel_spi_encoder.sv
// A word is taken in the idle state and captured; in the execute state its result
// enters the output register once that register is free. A new word is taken only
// after the last has executed, by the capture and execute steps of the controller around
// the store read port. A clear adds a sweep that zeroes the store, one entry a cycle.
// Reset: asynchronous, active low; state and config registers take defaults and the store is
// swept over every entry before the first word is taken (config writes always taken).
`default_nettype none
module led_pixel_spi_encoder #(
	parameter int unsigned MAX_LEDS = 64
) (
	input wire logic     clk,
	input wire logic     arst_n,
	lpse_item_if.sink    item,
	lpse_result_if.source result,
	lpse_cfg_if.sink     cfg
);
	import lpse_pkg::*;

	lpse_cmd_t  cmd;
	lpse_stat_t stat;

	// sequence the words
	lpse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// store, counters and result register
	lpse_dp #(
		.MAX_LEDS(MAX_LEDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (item.func),
		.pixel_index (item.pixel_index),
		.red         (item.red),
		.green       (item.green),
		.blue        (item.blue),
		.cfg_valid   (cfg.valid),
		.cfg_ready   (cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.spi_byte    (result.spi_byte),
		.byte_valid  (result.byte_valid),
		.last        (result.last),
		.status      (result.status)
	);
endmodule
`default_nettype wire

### design/lpse_ram.sv
// Generic single write port RAM with registered read
`default_nettype none
module lpse_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### design/lpse_ctrl.sv
// Controller state machine of the LED pixel SPI encoder
`default_nettype none
`include "assert_macros.svh"
module lpse_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire lpse_pkg::lpse_stat_t stat,
	output lpse_pkg::lpse_cmd_t      cmd
);
	import lpse_pkg::*;

	typedef enum logic [2:0] {
		ST_SWEEP = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// hold the state, start with the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence: sweep the store, take a word, execute it once the result slot is free
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.out_free) begin
					cmd.execute = 1'b1;
					state_d     = stat.clear_go ? ST_SWEEP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_RST(a_no_accept_twice, clk, arst_n, (item_valid && item_ready) |=> !item_ready)
	`ASSERT_RST(a_clear_sweeps, clk, arst_n, (cmd.execute && stat.clear_go) |=> cmd.sweep)
	`ASSERT_RST(a_sweep_runs, clk, arst_n, (cmd.sweep && !stat.sweep_last) |=> cmd.sweep)
	`ASSERT_ALWAYS(a_sweep_excl, clk, !(cmd.sweep && cmd.execute))
endmodule
`default_nettype wire

### design/lpse_dp.sv
// Datapath of the LED pixel SPI encoder: registers, pixel store, frame counters
`default_nettype none
module lpse_dp #(
	parameter int unsigned MAX_LEDS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lpse_pkg::lpse_cmd_t                 cmd,
	output lpse_pkg::lpse_stat_t                     stat,
	input  wire logic [lpse_pkg::FUNC_W-1:0]         func,
	input  wire logic [lpse_pkg::IDX_IN_W-1:0]       pixel_index,
	input  wire logic [lpse_pkg::COLOR_W-1:0]        red,
	input  wire logic [lpse_pkg::COLOR_W-1:0]        green,
	input  wire logic [lpse_pkg::COLOR_W-1:0]        blue,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lpse_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lpse_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic      [lpse_pkg::COLOR_W-1:0]        spi_byte,
	output logic                                     byte_valid,
	output logic                                     last,
	output logic                                     status
);
	import lpse_pkg::*;

	localparam int unsigned IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int unsigned POS_W = $clog2(MAX_LEDS + 1);

	// captured input word
	func_t               func_q;
	logic [IDX_IN_W-1:0] idx_q;
	logic [COLOR_W-1:0]  red_q;
	logic [COLOR_W-1:0]  green_q;
	logic [COLOR_W-1:0]  blue_q;

	// configuration registers
	logic [LED_COUNT_W-1:0] led_count_q;
	logic [TAIL_W-1:0]      reset_bytes_q;
	logic [COLOR_W-1:0]     high_code_q;
	logic [COLOR_W-1:0]     low_code_q;

	// frame state
	logic             active_q;
	logic [POS_W-1:0] led_q;
	logic [1:0]       col_q;
	logic [2:0]       bit_q;
	logic [TAIL_W-1:0] tail_q;
	logic [IDX_W-1:0] sweep_q;

	// next frame state and result
	logic              active_d;
	logic [POS_W-1:0]  led_d;
	logic [1:0]        col_d;
	logic [2:0]        bit_d;
	logic [TAIL_W-1:0] tail_d;
	logic [COLOR_W-1:0] r_byte;
	logic              r_valid;
	logic              r_last;
	logic              r_status;
	logic              wr_item;
	logic              clear_go;

	logic [POS_W-1:0]   count;
	logic [POS_W-1:0]   led_inc;
	logic [TAIL_W-1:0]  tail_inc;
	logic [PIXEL_W-1:0] pix;
	logic [COLOR_W-1:0] comp;
	logic               sweep_last;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [PIXEL_W-1:0] ram_wdata;

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func_t'(func);
			idx_q   <= pixel_index;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	// write configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q   <= LED_COUNT_RST;
			reset_bytes_q <= RESET_BYTES_RST;
			high_code_q   <= HIGH_CODE_RST;
			low_code_q    <= LOW_CODE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LED_COUNT:   led_count_q   <= cfg_data[LED_COUNT_W-1:0];
				CFG_RESET_BYTES: reset_bytes_q <= cfg_data;
				CFG_HIGH_CODE:   high_code_q   <= cfg_data;
				CFG_LOW_CODE:    low_code_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate the LED count at the store depth
	assign count = (32'(led_count_q) > MAX_LEDS) ? POS_W'(MAX_LEDS) : POS_W'(led_count_q);
	assign led_inc  = led_q + POS_W'(1);
	assign tail_inc = tail_q + TAIL_W'(1);

	// pick the color being sent
	always_comb begin
		case (col_q)
			COL_GREEN: comp = pix[2*COLOR_W-1:COLOR_W];
			COL_RED:   comp = pix[3*COLOR_W-1:2*COLOR_W];
			default:   comp = pix[COLOR_W-1:0];
		endcase
	end

	// execute the captured word
	always_comb begin
		active_d = active_q;
		led_d    = led_q;
		col_d    = col_q;
		bit_d    = bit_q;
		tail_d   = tail_q;
		r_byte   = '0;
		r_valid  = 1'b0;
		r_last   = 1'b0;
		r_status = 1'b0;
		wr_item  = 1'b0;
		clear_go = 1'b0;
		case (func_q)
			FN_CLEAR: begin
				if (active_q) begin
					r_status = 1'b1;
				end else begin
					clear_go = 1'b1;
				end
			end
			FN_WRITE: begin
				if (active_q || (32'(idx_q) >= 32'(count))) begin
					r_status = 1'b1;
				end else begin
					wr_item = 1'b1;
				end
			end
			FN_START: begin
				if (active_q) begin
					r_status = 1'b1;
				end else if ((count != '0) || (reset_bytes_q != '0)) begin
					active_d = 1'b1;
					led_d    = '0;
					col_d    = COL_GREEN;
					bit_d    = '0;
					tail_d   = '0;
				end
			end
			FN_TICK: begin
				if (active_q) begin
					r_valid = 1'b1;
					if (led_q < count) begin
						// one code byte per color bit, msb first
						r_byte = comp[~bit_q] ? high_code_q : low_code_q;
						if (bit_q != 3'd7) begin
							bit_d = bit_q + 3'd1;
						end else begin
							bit_d = '0;
							if (col_q < COL_BLUE) begin
								col_d = col_q + 2'd1;
							end else begin
								col_d = COL_GREEN;
								led_d = led_inc;
								if ((led_inc >= count) && (reset_bytes_q == '0)) begin
									r_last   = 1'b1;
									active_d = 1'b0;
								end
							end
						end
					end else begin
						// latch gap: zero bytes, the last one flagged
						tail_d = tail_inc;
						if ((tail_inc >= reset_bytes_q) || (tail_inc == '0)) begin
							r_last   = 1'b1;
							active_d = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			led_q    <= '0;
			col_q    <= COL_GREEN;
			bit_q    <= '0;
			tail_q   <= '0;
		end else if (cmd.execute) begin
			active_q <= active_d;
			led_q    <= led_d;
			col_q    <= col_d;
			bit_q    <= bit_d;
			tail_q   <= tail_d;
		end
	end

	// step the clearing sweep over every entry
	assign sweep_last = (sweep_q == IDX_W'(MAX_LEDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_last ? '0 : sweep_q + IDX_W'(1);
		end
	end

	// pixel store: sweep writes zero, a write word stores its color
	assign ram_we    = cmd.sweep | (cmd.execute & wr_item);
	assign ram_waddr = cmd.sweep ? sweep_q : IDX_W'(idx_q);
	assign ram_wdata = cmd.sweep ? '0 : {red_q, green_q, blue_q};

	lpse_ram #(
		.WIDTH(PIXEL_W),
		.DEPTH(MAX_LEDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (IDX_W'(led_q)),
		.rdata (pix)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.execute) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			spi_byte   <= r_byte;
			byte_valid <= r_valid;
			last       <= r_last;
			status     <= r_status;
		end
	end

	// status back to the controller
	assign stat.out_free   = !res_valid || res_ready;
	assign stat.clear_go   = clear_go;
	assign stat.sweep_last = sweep_last;
endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the LED pixel SPI encoder: random and directed words, scored in order
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lpse_pkg::*;

	localparam int unsigned LEDS        = 64;
	localparam int unsigned WORD_TARGET = 1350;
	localparam int unsigned PHASE_WORDS = 90;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned LONG_FRAME  = 300;
	localparam int unsigned MAX_SHOWN   = 10;

	// one input word as the sender offers it
	typedef struct packed {
		func_t               fn;
		logic [IDX_IN_W-1:0] idx;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
	} pixel_word_t;

	// one result word
	typedef struct packed {
		logic [COLOR_W-1:0] spi_byte;
		logic               byte_valid;
		logic               last;
		logic               status;
	} spi_out_t;

	logic clk = 1'b0;
	logic arst_n;

	lpse_item_if   item_ch ();
	lpse_result_if result_ch ();
	lpse_cfg_if    cfg_ch ();

	led_pixel_spi_encoder #(.MAX_LEDS(LEDS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// words waiting to be sent and results waiting to arrive
	pixel_word_t pending_words[$];
	spi_out_t    spi_expect[$];

	// predictor state and its copy of the registers
	logic [PIXEL_W-1:0]     led_colors [LEDS];
	logic                   frame_on;
	logic [LED_COUNT_W-1:0] led_pos;
	logic [1:0]             color_pos;
	logic [2:0]             bit_pos;
	logic [TAIL_W-1:0]      tail_cnt;
	logic [LED_COUNT_W-1:0] led_count_reg;
	logic [TAIL_W-1:0]      reset_bytes_reg;
	logic [COLOR_W-1:0]     high_code_reg;
	logic [COLOR_W-1:0]     low_code_reg;

	// settings as last written by the stimulus, used to size frames
	int unsigned plan_leds;
	int unsigned plan_tail;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_go        = 1'b0;
	logic        recv_hold      = 1'b0;

	int unsigned errors          = 0;
	int unsigned words_pushed    = 0;
	int unsigned words_taken     = 0;
	int unsigned results_checked = 0;
	int unsigned frames_done     = 0;
	int unsigned settings_used   = 0;
	int unsigned quiet_cycles    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LED_COUNT_W-1:0] active_leds(input logic [LED_COUNT_W-1:0] count);
		return (count > LEDS) ? LED_COUNT_W'(LEDS) : count;
	endfunction

	// advance the predictor by one word and return the result it calls for
	function automatic spi_out_t encode_word(input pixel_word_t w);
		spi_out_t               res;
		logic [LED_COUNT_W-1:0] cnt;
		logic [PIXEL_W-1:0]     px;
		logic [COLOR_W-1:0]     comp;
		res = '0;
		cnt = active_leds(led_count_reg);
		case (w.fn)
		FN_CLEAR: begin
			if (frame_on) begin
				res.status = 1'b1;
			end else begin
				foreach (led_colors[i]) led_colors[i] = '0;
			end
		end
		FN_WRITE: begin
			if (frame_on || w.idx >= cnt) begin
				res.status = 1'b1;
			end else begin
				led_colors[w.idx] = {w.red, w.green, w.blue};
			end
		end
		FN_START: begin
			if (frame_on) begin
				res.status = 1'b1;
			end else if (cnt != '0 || reset_bytes_reg != '0) begin
				frame_on  = 1'b1;
				led_pos   = '0;
				color_pos = COL_GREEN;
				bit_pos   = '0;
				tail_cnt  = '0;
			end
		end
		default: begin
			if (frame_on) begin
				res.byte_valid = 1'b1;
				if (led_pos < cnt) begin
					// pixel data: green, red, blue, msb first
					px = led_colors[led_pos[IDX_IN_W-1:0]];
					case (color_pos)
					COL_GREEN: comp = px[2*COLOR_W-1:COLOR_W];
					COL_RED:   comp = px[3*COLOR_W-1:2*COLOR_W];
					default:   comp = px[COLOR_W-1:0];
					endcase
					res.spi_byte = comp[3'd7 - bit_pos] ? high_code_reg : low_code_reg;
					if (bit_pos != 3'd7) begin
						bit_pos = bit_pos + 3'd1;
					end else begin
						bit_pos = '0;
						if (color_pos != COL_BLUE) begin
							color_pos = color_pos + 2'd1;
						end else begin
							color_pos = COL_GREEN;
							led_pos   = led_pos + LED_COUNT_W'(1);
							if (led_pos >= cnt && reset_bytes_reg == '0) res.last = 1'b1;
						end
					end
				end else begin
					// latch gap: zero bytes, a wrapped count also ends it
					tail_cnt = tail_cnt + TAIL_W'(1);
					if (tail_cnt >= reset_bytes_reg || tail_cnt == '0) res.last = 1'b1;
				end
				if (res.last) begin
					frame_on    = 1'b0;
					frames_done = frames_done + 1;
				end
			end
		end
		endcase
		return res;
	endfunction

	function automatic void note_error(input string msg);
		errors = errors + 1;
		if (errors <= MAX_SHOWN) $display("ERROR: %s", msg);
	endfunction

	// driver: offer the next pending word once the current one is taken
	always @(posedge clk or negedge arst_n) begin : driver
		pixel_word_t w;
		logic        offer;
		if (!arst_n) begin
			item_ch.valid       <= 1'b0;
			item_ch.func        <= FN_CLEAR;
			item_ch.pixel_index <= '0;
			item_ch.red         <= '0;
			item_ch.green       <= '0;
			item_ch.blue        <= '0;
		end else if (!item_ch.valid || item_ch.ready) begin
			offer = pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct;
			if (offer) begin
				w = pending_words.pop_front();
				item_ch.func        <= w.fn;
				item_ch.pixel_index <= w.idx;
				item_ch.red         <= w.red;
				item_ch.green       <= w.green;
				item_ch.blue        <= w.blue;
			end
			item_ch.valid <= offer;
		end
	end

	// monitor: predict on each taken word, score each taken result, drive ready
	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_word_t w;
		spi_out_t    got;
		spi_out_t    exp_out;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			foreach (led_colors[i]) led_colors[i] = '0;
			frame_on        = 1'b0;
			led_pos         = '0;
			color_pos       = COL_GREEN;
			bit_pos         = '0;
			tail_cnt        = '0;
			led_count_reg   = LED_COUNT_RST;
			reset_bytes_reg = RESET_BYTES_RST;
			high_code_reg   = HIGH_CODE_RST;
			low_code_reg    = LOW_CODE_RST;
			spi_expect.delete();
		end else begin
			// track register writes
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
				CFG_LED_COUNT:   led_count_reg   = cfg_ch.data[LED_COUNT_W-1:0];
				CFG_RESET_BYTES: reset_bytes_reg = cfg_ch.data;
				CFG_HIGH_CODE:   high_code_reg   = cfg_ch.data;
				CFG_LOW_CODE:    low_code_reg    = cfg_ch.data;
				default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready) begin
				w.fn    = func_t'(item_ch.func);
				w.idx   = item_ch.pixel_index;
				w.red   = item_ch.red;
				w.green = item_ch.green;
				w.blue  = item_ch.blue;
				spi_expect.push_back(encode_word(w));
				words_taken = words_taken + 1;
			end
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.spi_byte, result_ch.byte_valid, result_ch.last, result_ch.status};
				if (spi_expect.size() == 0) begin
					note_error($sformatf("unexpected result byte %02h valid %0b last %0b status %0b",
						got.spi_byte, got.byte_valid, got.last, got.status));
				end else begin
					exp_out = spi_expect.pop_front();
					if (got.spi_byte !== exp_out.spi_byte || got.byte_valid !== exp_out.byte_valid ||
					    got.last !== exp_out.last || got.status !== exp_out.status) begin
						note_error($sformatf({"result %0d: expected byte %02h valid %0b last %0b ",
							"status %0b, got byte %02h valid %0b last %0b status %0b"},
							results_checked, exp_out.spi_byte, exp_out.byte_valid, exp_out.last,
							exp_out.status, got.spi_byte, got.byte_valid, got.last, got.status));
					end
					results_checked = results_checked + 1;
				end
			end
			result_ch.ready <= !recv_hold && $urandom_range(99) >= recv_stall_pct;
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin : receiver_holdoff
		wait (hold_go);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// watchdog: end the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_word(input func_t fn, input int unsigned idx, input int unsigned r,
		input int unsigned g, input int unsigned b);
		pixel_word_t w;
		w.fn    = fn;
		w.idx   = IDX_IN_W'(idx);
		w.red   = COLOR_W'(r);
		w.green = COLOR_W'(g);
		w.blue  = COLOR_W'(b);
		pending_words.push_back(w);
		words_pushed = words_pushed + 1;
	endtask

	// word of the given operation with random fields
	task automatic add_op(input func_t fn);
		add_word(fn, $urandom_range(63), $urandom_range(255), $urandom_range(255),
			$urandom_range(255));
	endtask

	task automatic add_ticks(input int unsigned n);
		repeat (n) add_op(FN_TICK);
	endtask

	function automatic int unsigned frame_len();
		return ((plan_leds > LEDS) ? LEDS : plan_leds) * 24 + plan_tail;
	endfunction

	// ticks to finish a frame that may be running, if its length is within LONG_FRAME
	function automatic int unsigned flush_len();
		return (frame_len() > LONG_FRAME) ? 40 : frame_len() + 1;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_registers(input logic [CFG_DATA_W-1:0] count_data,
		input logic [CFG_DATA_W-1:0] tail, input logic [CFG_DATA_W-1:0] hi,
		input logic [CFG_DATA_W-1:0] lo);
		write_reg(CFG_LED_COUNT, count_data);
		write_reg(CFG_RESET_BYTES, tail);
		write_reg(CFG_HIGH_CODE, hi);
		write_reg(CFG_LOW_CODE, lo);
		plan_leds     = 32'(count_data[LED_COUNT_W-1:0]);
		plan_tail     = 32'(tail);
		settings_used = settings_used + 1;
	endtask

	// wait until every word is sent and every result has arrived
	task automatic drain();
		while (pending_words.size() != 0 || item_ch.valid || spi_expect.size() != 0)
			@(posedge clk);
	endtask

	// well-formed frame: optional clear, writes, start, ticks with a few busy words mixed in
	task automatic add_frame();
		int unsigned leds;
		int unsigned ticks;
		int unsigned n_writes;
		leds     = (plan_leds > LEDS) ? LEDS : plan_leds;
		ticks    = (frame_len() > LONG_FRAME) ? $urandom_range(20, 80) : frame_len();
		n_writes = $urandom_range(1, (leds < 5) ? leds + 1 : 6);
		if ($urandom_range(1)) add_op(FN_CLEAR);
		repeat (n_writes) begin
			add_word(FN_WRITE,
				(leds == 0 || $urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(leds - 1),
				$urandom_range(255), $urandom_range(255), $urandom_range(255));
		end
		add_op(FN_START);
		repeat (ticks) begin
			if ($urandom_range(24) == 0) add_op(func_t'($urandom_range(2)));
			add_op(FN_TICK);
		end
		add_ticks($urandom_range(2));
	endtask

	initial begin : stimulus
		int unsigned           phase;
		int unsigned           phase_start;
		int unsigned           pick;
		logic [CFG_DATA_W-1:0] count_data;
		logic [CFG_DATA_W-1:0] tail;
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.func        = FN_CLEAR;
		item_ch.pixel_index = '0;
		item_ch.red         = '0;
		item_ch.green       = '0;
		item_ch.blue        = '0;
		result_ch.ready     = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = CFG_LED_COUNT;
		cfg_ch.data         = '0;
		plan_leds           = 32'(LED_COUNT_RST);
		plan_tail           = 32'(RESET_BYTES_RST);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle tick, write extremes, clear, start and the first color bits
		add_word(FN_TICK, 0, 0, 0, 0);
		add_word(FN_WRITE, 63, 8'hFF, 8'hFF, 8'hFF);
		add_word(FN_WRITE, 0, 8'h00, 8'h00, 8'h00);
		add_word(FN_CLEAR, 0, 0, 0, 0);
		add_word(FN_WRITE, 0, 8'h81, 8'hA5, 8'h3C);
		add_word(FN_START, 0, 0, 0, 0);
		add_ticks(8);
		// busy frame: clear, write and start are refused
		add_word(FN_WRITE, 1, 8'h11, 8'h22, 8'h33);
		add_word(FN_CLEAR, 0, 0, 0, 0);
		add_word(FN_START, 0, 0, 0, 0);
		drain();
		// shrink the frame mid-flight: the tail is entered with nothing left, one zero byte ends it
		set_registers(8'd0, 8'd0, HIGH_CODE_RST, LOW_CODE_RST);
		add_ticks(2);
		drain();
		// led count above capacity saturates, so index 63 is still valid
		set_registers(8'hFF, 8'd0, 8'hFF, 8'h00);
		add_word(FN_WRITE, 63, 8'h01, 8'h80, 8'hFE);
		drain();
		// index at the led count is rejected
		set_registers(8'd2, 8'd1, HIGH_CODE_RST, LOW_CODE_RST);
		add_word(FN_WRITE, 2, 8'hAA, 8'h55, 8'hC3);
		add_word(FN_WRITE, 1, 8'h55, 8'hAA, 8'h3C);
		drain();
		// empty frame: start stays idle
		set_registers(8'd0, 8'd0, HIGH_CODE_RST, LOW_CODE_RST);
		add_word(FN_START, 0, 0, 0, 0);
		add_word(FN_TICK, 0, 0, 0, 0);
		drain();
		// no leds: the frame is the latch gap alone
		set_registers(8'd0, 8'd3, HIGH_CODE_RST, LOW_CODE_RST);
		add_word(FN_START, 0, 0, 0, 0);
		add_ticks(3);
		drain();

		// random phases, each with its own settings and idle mix
		phase = 0;
		while (words_pushed < WORD_TARGET) begin
			case (phase)
			0: set_registers(8'd1, 8'd0, 8'hFF, 8'h00);
			1: set_registers(8'd0, 8'd255, 8'h00, 8'hFF);
			2: set_registers(8'hC0, RESET_BYTES_RST, CFG_DATA_W'($urandom_range(255)),
				CFG_DATA_W'($urandom_range(255)));
			3: set_registers(8'd3, 8'd0, CFG_DATA_W'($urandom_range(255)),
				CFG_DATA_W'($urandom_range(255)));
			default: begin
				pick = $urandom_range(9);
				count_data = (pick < 7) ? CFG_DATA_W'($urandom_range(3)) :
					(pick < 9) ? CFG_DATA_W'($urandom_range(4, 8)) :
					CFG_DATA_W'($urandom_range(255));
				pick = $urandom_range(9);
				tail = (pick < 5) ? CFG_DATA_W'($urandom_range(1, 4)) : (pick < 8) ? 8'd0 :
					CFG_DATA_W'($urandom_range(255));
				set_registers(count_data, tail, CFG_DATA_W'($urandom_range(255)),
					CFG_DATA_W'($urandom_range(255)));
			end
			endcase
			case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
			default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			// finish a frame left running from the last phase, under the new settings, if its length is within LONG_FRAME
			if (frame_on) add_ticks(flush_len());
			phase_start = words_pushed;
			while (words_pushed - phase_start < PHASE_WORDS) begin
				if ($urandom_range(9) < 7) begin
					add_frame();
				end else begin
					// noise: random operations, then enough ticks to close any frame they began that is within LONG_FRAME
					repeat ($urandom_range(3, 10)) add_op(func_t'($urandom_range(3)));
					add_ticks(flush_len());
				end
			end
			if (phase == 1) hold_go = 1'b1;
			drain();
			phase = phase + 1;
		end

		// let any stray result show up before the verdict
		repeat (LEDS + 20) @(posedge clk);
		$display("Ran %0d input words and scored %0d results over %0d register settings.",
			words_taken, results_checked, settings_used);
		$display("Frames finished: %0d; idle mixes on both sides plus one long receiver hold-off.",
			frames_done);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("Mismatches: %0d", errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### led_pixel_spi_encoder.f
+incdir+design
design/lpse_pkg.sv
design/lpse_item_if.sv
design/lpse_result_if.sv
design/lpse_cfg_if.sv
design/lpse_ram.sv
design/lpse_ctrl.sv
design/lpse_dp.sv
design/led_pixel_spi_encoder.sv
test/testbench.sv
